// ===== src/hsc_pkg.sv =====
package hsc_pkg;

    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned LEN_W        = 8;
    localparam int unsigned SAT2_W       = 2;

    localparam logic [CHAR_W-1:0] HYPHEN_CHAR   = 8'h2D;
    localparam logic [CHAR_W-1:0] DOT_CHAR      = 8'h2E;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 8'd253;
    localparam logic [LEN_W-1:0]  BYTE_CNT_MAX  = 8'd255;
    localparam logic [SAT2_W-1:0] SAT2_MAX      = 2'd2;

    // Result item in tdata: name_valid at bit 0, padded to a byte
    localparam int unsigned OUT_TDATA_W = 8;

    function automatic logic is_letter(input logic [CHAR_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

// ===== src/hostname_syntax_checker.sv =====
// Hostname syntax checker: one name byte per transfer, verdict on the tlast byte.
// Throughput: one byte per cycle, including back-to-back names, while the skid register is empty.
// The final byte's verdict is registered in the result register, or in the skid register if stalled.
// A two-entry output (result register plus skid register) lets input run on while
// a verdict waits; s_axis_tready drops only when both entries are full.
// Reset (i_rst_n low, synchronous) clears name state and output, limit back to 253.
module hostname_syntax_checker
    import hsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_wr_en,
    input  logic [LEN_W-1:0]       i_cfg_wr_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_byte
    input  logic                   s_axis_tlast,   // is_final

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] name_valid, [7:1] zero
);

    logic [LEN_W-1:0]  r_max_len;
    logic [LEN_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [SAT2_W-1:0] r_lbl_len, n_lbl_len;
    logic [SAT2_W-1:0] r_lbl_cnt, n_lbl_cnt;
    logic              r_prev_hyph, n_prev_hyph;
    logic              r_all_alpha, n_all_alpha;
    logic              r_failed, n_failed;

    logic              r_out_valid, r_out_data;
    logic              r_skid_valid, r_skid_data;

    logic              in_xfer, out_xfer, push, verdict;
    logic [CHAR_W-1:0] b;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign push          = in_xfer && s_axis_tlast;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_out_data};

    always_comb begin
        n_failed    = r_failed || (r_byte_cnt >= r_max_len);
        n_byte_cnt  = (r_byte_cnt < BYTE_CNT_MAX) ? r_byte_cnt + 1'b1 : r_byte_cnt;
        n_lbl_len   = r_lbl_len;
        n_lbl_cnt   = r_lbl_cnt;
        n_prev_hyph = r_prev_hyph;
        n_all_alpha = r_all_alpha;

        if (b == DOT_CHAR) begin
            if ((r_lbl_len == '0) || r_prev_hyph) begin
                n_failed = 1'b1;
            end
            if (r_lbl_cnt < SAT2_MAX) begin
                n_lbl_cnt = r_lbl_cnt + 1'b1;
            end
            n_lbl_len   = '0;
            n_prev_hyph = 1'b0;
            n_all_alpha = 1'b1;
        end else if (b == HYPHEN_CHAR) begin
            // no leading hyphen, no doubled hyphen
            if ((r_lbl_len == '0) || r_prev_hyph) begin
                n_failed = 1'b1;
            end
            n_prev_hyph = 1'b1;
            n_all_alpha = 1'b0;
            if (r_lbl_len < SAT2_MAX) begin
                n_lbl_len = r_lbl_len + 1'b1;
            end
        end else if (is_letter(b) || is_digit(b)) begin
            n_prev_hyph = 1'b0;
            if (!is_letter(b)) begin
                n_all_alpha = 1'b0;
            end
            if (r_lbl_len < SAT2_MAX) begin
                n_lbl_len = r_lbl_len + 1'b1;
            end
        end else begin
            n_failed = 1'b1;
        end

        // last label: two or more letters, after at least one dot
        verdict = !n_failed && (n_lbl_cnt != '0) && (n_lbl_len >= SAT2_MAX)
                  && !n_prev_hyph && n_all_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || push) begin
            r_byte_cnt  <= '0;
            r_lbl_len   <= '0;
            r_lbl_cnt   <= '0;
            r_prev_hyph <= 1'b0;
            r_all_alpha <= 1'b1;
            r_failed    <= 1'b0;
        end else if (in_xfer) begin
            r_byte_cnt  <= n_byte_cnt;
            r_lbl_len   <= n_lbl_len;
            r_lbl_cnt   <= n_lbl_cnt;
            r_prev_hyph <= n_prev_hyph;
            r_all_alpha <= n_all_alpha;
            r_failed    <= n_failed;
        end
    end

    // skid only fills when a verdict arrives while the result register is stuck
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
                r_out_data  <= verdict;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= verdict;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== src/hsc_checker.sv =====
module hsc_checker
    import hsc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // output empty after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // input back-pressure only while a verdict is pending
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // a non-final byte never produces a verdict
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("verdict without final byte");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("padding bits set");

endmodule

bind hostname_syntax_checker hsc_checker u_hsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
